@@ src/isp_pkg.sv @@
package isp_pkg;

    // words of one solid table entry
    localparam int WORDS_PER_SOLID = 13;
    localparam logic [3:0] W_SHAPE   = 4'd0;
    localparam logic [3:0] W_CX      = 4'd1;
    localparam logic [3:0] W_RADIUS  = 4'd4;
    localparam logic [3:0] W_HX      = 4'd5;
    localparam logic [3:0] W_WIDTH   = 4'd8;
    localparam logic [3:0] W_PENALTY = 4'd9;
    localparam logic [3:0] W_VX      = 4'd10;
    localparam logic [3:0] W_LAST    = 4'd12;

    localparam logic signed [31:0] SHAPE_SPHERE = 32'sd0;
    localparam logic signed [31:0] SHAPE_BOX    = 32'sd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CELL = 1'b1;

    // register indexes
    localparam logic [1:0] REG_SOLID_COUNT = 2'd0;
    localparam logic [1:0] REG_MODE        = 2'd1;
    localparam logic [1:0] REG_BLEND       = 2'd2;
    localparam logic [1:0] REG_DWIDTH      = 2'd3;

    localparam logic [30:0] DWIDTH_RESET = 31'd65536;
    localparam logic [16:0] ONE_Q        = 17'd65536;

    // controller states, also the datapath phase
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_DIST  = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_FRAC  = 3'd5;
    localparam logic [2:0] ST_APPLY = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    // last step of each multi-cycle phase
    localparam logic [5:0] DIST_LAST  = 6'd3;
    localparam logic [5:0] SQRT_LAST  = 6'd32;
    localparam logic [5:0] DIV_LAST   = 6'd19;
    localparam logic [5:0] APPLY_LAST = 6'd5;

    typedef struct packed {
        logic [2:0] phase;
        logic [5:0] step;
        logic       cell_ld;
        logic       mem_wr;
        logic       base_clr;
        logic       base_adv;
        logic       out_ld;
        logic       hit;
        logic [2:0] hit_slot;
    } t_cmd;

    typedef struct packed {
        logic sphere;
        logic box;
        logic f_pos;
    } t_stat;

    // divide by 65536, truncating toward zero
    function automatic logic signed [51:0] trunc16(input logic signed [67:0] x);
        logic signed [67:0] adj;
        adj = x + (x[67] ? 68'sd65535 : 68'sd0);
        return 52'(adj >>> 16);
    endfunction

endpackage

@@ src/isp_in_if.sv @@
interface isp_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [2:0]         slot;
    logic [3:0]         word_select;
    logic signed [31:0] word_value;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
    logic signed [31:0] vel_u;
    logic signed [31:0] vel_v;
    logic signed [31:0] vel_w;

    modport source (output valid, op, slot, word_select, word_value, cell_x, cell_y, cell_z,
                    vel_u, vel_v, vel_w, input ready);
    modport sink (input valid, op, slot, word_select, word_value, cell_x, cell_y, cell_z,
                  vel_u, vel_v, vel_w, output ready);
endinterface

@@ src/isp_out_if.sv @@
interface isp_out_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] out_x;
    logic signed [VALUE_WIDTH-1:0] out_y;
    logic signed [VALUE_WIDTH-1:0] out_z;
    logic                          matched;
    logic [2:0]                    matched_slot;

    modport source (output valid, out_x, out_y, out_z, matched, matched_slot, input ready);
    modport sink (input valid, out_x, out_y, out_z, matched, matched_slot, output ready);
endinterface

@@ src/immersed_solid_penalty_cell_core.sv @@
// Immersed moving-solid penalty forcing, one grid cell per item. A table of up to
// MAX_SOLIDS solids (sphere or box, 13 words each) is loaded by op 0 items, one word
// per item; a load gives no result. An op 1 item carries a cell
// center and fluid velocity; the solids 0 .. solid_count-1 are examined in order:
// signed distance (euclidean minus radius, or largest per-axis box distance), then
// the fraction clamp(0.5 - d/width, 0, 1), and the first solid with a positive
// fraction wins. mode 0 returns -penalty*f*(vel - solid_vel), mode 1 returns vel
// blended toward the solid velocity by freeze_blend*f; all Q16.16, saturated to
// VALUE_WIDTH. Steps of a cell item: one table word is read per cycle from the
// single-port table; each solid passes fetch (shape to width words), distance,
// divider and decision, and a sphere adds the bit-serial square root after the
// distance step; an unknown shape is skipped after its fetch. A match fetches
// the penalty and velocity words, multiplies, then loads the result register.
// The block holds one cell at a time; the result register lets the next item be
// accepted while a result still waits. Registers (APB, byte address 4*index):
// solid_count, mode, freeze_blend, default_width (reset 1.0).
module immersed_solid_penalty_cell_core import isp_pkg::*; #(
    parameter int MAX_SOLIDS  = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isp_in_if.sink      i_in,
    isp_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = $clog2(MAX_SOLIDS + 1);

    // configuration registers
    logic [3:0]    r_solid_count;
    logic          r_mode;
    logic [16:0]   r_blend;
    logic [30:0]   r_dwidth;
    logic          cfg_wr;
    logic [CW-1:0] count_eff;
    t_cmd          cmd;
    t_stat         stat;
    logic          in_ready;
    logic          out_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solid_count <= '0;
            r_mode        <= 1'b0;
            r_blend       <= '0;
            r_dwidth      <= DWIDTH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SOLID_COUNT: r_solid_count <= pwdata[3:0];
                REG_MODE:        r_mode        <= pwdata[0];
                REG_BLEND:       r_blend       <= pwdata[16:0];
                REG_DWIDTH:      r_dwidth      <= pwdata[30:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SOLID_COUNT: prdata = {28'd0, r_solid_count};
            REG_MODE:        prdata = {31'd0, r_mode};
            REG_BLEND:       prdata = {15'd0, r_blend};
            REG_DWIDTH:      prdata = {1'b0, r_dwidth};
        endcase
    end

    // counts past the table size examine the whole table
    always_comb begin
        if (int'(r_solid_count) > MAX_SOLIDS) begin
            count_eff = CW'(MAX_SOLIDS);
        end else begin
            count_eff = CW'(r_solid_count);
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    isp_ctrl #(.MAX_SOLIDS(MAX_SOLIDS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.op),
        .i_out_ready (o_out.ready),
        .i_count     (count_eff),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    isp_dp #(.MAX_SOLIDS(MAX_SOLIDS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (r_mode),
        .i_blend        (r_blend),
        .i_dwidth       (r_dwidth),
        .i_slot         (i_in.slot),
        .i_word_select  (i_in.word_select),
        .i_word_value   (i_in.word_value),
        .i_cell_x       (i_in.cell_x),
        .i_cell_y       (i_in.cell_y),
        .i_cell_z       (i_in.cell_z),
        .i_vel_u        (i_in.vel_u),
        .i_vel_v        (i_in.vel_v),
        .i_vel_w        (i_in.vel_w),
        .o_out_x        (o_out.out_x),
        .o_out_y        (o_out.out_y),
        .o_out_z        (o_out.out_z),
        .o_matched      (o_out.matched),
        .o_matched_slot (o_out.matched_slot)
    );
endmodule

@@ src/isp_ctrl.sv @@
module isp_ctrl import isp_pkg::*; #(
    parameter int MAX_SOLIDS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_op,
    input  logic                               i_out_ready,
    input  logic [$clog2(MAX_SOLIDS+1)-1:0]    i_count,
    input  t_stat                              i_stat,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    output t_cmd                               o_cmd
);
    localparam int CW = $clog2(MAX_SOLIDS + 1);

    logic [2:0]    r_state, n_state;
    logic [5:0]    r_step, n_step;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_hit, n_hit;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] idx_inc;

    assign idx_inc     = r_idx + CW'(1);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step + 6'd1;
        n_idx       = r_idx;
        n_count     = r_count;
        n_hit       = r_hit;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd          = '0;
        o_cmd.phase    = r_state;
        o_cmd.step     = r_step;
        o_cmd.hit      = r_hit;
        o_cmd.hit_slot = 3'(r_idx);
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_step     = 6'd0;
                if (i_in_valid) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.mem_wr = 1'b1;
                    end else begin
                        o_cmd.cell_ld  = 1'b1;
                        o_cmd.base_clr = 1'b1;
                        n_idx   = '0;
                        n_hit   = 1'b0;
                        n_count = i_count;
                        n_state = (i_count == '0) ? ST_DONE : ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                if (r_hit && r_step[3:0] == W_LAST) begin
                    n_state = ST_APPLY;
                    n_step  = 6'd0;
                end else if (!r_hit && r_step[3:0] == W_WIDTH) begin
                    n_step = 6'd0;
                    if (i_stat.sphere || i_stat.box) begin
                        n_state = ST_DIST;
                    end else if (idx_inc == r_count) begin
                        // unknown shape never matches
                        n_state = ST_DONE;
                    end else begin
                        n_idx          = idx_inc;
                        o_cmd.base_adv = 1'b1;
                    end
                end
            end
            ST_DIST: begin
                if (r_step == DIST_LAST) begin
                    n_step  = 6'd0;
                    n_state = i_stat.sphere ? ST_SQRT : ST_DIV;
                end
            end
            ST_SQRT: begin
                if (r_step == SQRT_LAST) begin
                    n_step  = 6'd0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_step == DIV_LAST) begin
                    n_state = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (i_stat.f_pos) begin
                    n_hit   = 1'b1;
                    n_state = ST_FETCH;
                    n_step  = {2'b00, W_PENALTY};
                end else if (idx_inc == r_count) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx          = idx_inc;
                    o_cmd.base_adv = 1'b1;
                    n_state        = ST_FETCH;
                    n_step         = 6'd0;
                end
            end
            ST_APPLY: begin
                if (r_step == APPLY_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_ld = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

@@ src/isp_dp.sv @@
module isp_dp import isp_pkg::*; #(
    parameter int MAX_SOLIDS  = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  logic                          i_mode,
    input  logic [16:0]                   i_blend,
    input  logic [30:0]                   i_dwidth,
    input  logic [2:0]                    i_slot,
    input  logic [3:0]                    i_word_select,
    input  logic signed [31:0]            i_word_value,
    input  logic signed [31:0]            i_cell_x,
    input  logic signed [31:0]            i_cell_y,
    input  logic signed [31:0]            i_cell_z,
    input  logic signed [31:0]            i_vel_u,
    input  logic signed [31:0]            i_vel_v,
    input  logic signed [31:0]            i_vel_w,
    output logic signed [VALUE_WIDTH-1:0] o_out_x,
    output logic signed [VALUE_WIDTH-1:0] o_out_y,
    output logic signed [VALUE_WIDTH-1:0] o_out_z,
    output logic                          o_matched,
    output logic [2:0]                    o_matched_slot
);
    localparam int DEPTH = MAX_SOLIDS * WORDS_PER_SOLID;
    localparam int AW    = $clog2(DEPTH);
    localparam int WAW   = (AW > 7) ? AW : 7;
    localparam logic signed [67:0] SAT_HI = (68'sd1 <<< (VALUE_WIDTH - 1)) - 68'sd1;
    localparam logic signed [67:0] SAT_LO = -SAT_HI - 68'sd1;

    logic [31:0]        r_mem [DEPTH];
    logic signed [31:0] r_word [WORDS_PER_SOLID];
    logic [AW-1:0]      r_base;
    logic signed [31:0] r_cell [3];
    logic signed [31:0] r_vel [3];
    logic signed [67:0] r_prod;
    logic [63:0]        r_sum;
    logic signed [33:0] r_boxd;
    logic [63:0]        r_sq_n, r_sq_r, r_sq_bit;
    logic signed [34:0] r_d;
    logic [49:0]        r_num, r_den;
    logic [18:0]        r_q;
    logic               r_qsat;
    logic [16:0]        r_f;
    logic signed [33:0] r_coef;
    logic signed [51:0] r_res [3];

    logic [WAW-1:0]     wa_full;
    logic               wr_ok;
    logic [AW-1:0]      rd_addr;
    logic signed [32:0] dd [3];
    logic [31:0]        mag [3];
    logic [31:0]        mag_sel;
    logic signed [31:0] half_sel;
    logic signed [33:0] e_sel;
    logic [64:0]        sum_nx;
    logic [63:0]        sq_t;
    logic signed [34:0] d_now;
    logic [30:0]        w_eff;
    logic [33:0]        d_mag;
    logic [49:0]        num0;
    logic [49:0]        den_lim;
    logic signed [19:0] qs;
    logic signed [20:0] f_raw;
    logic [16:0]        f_now;
    logic [16:0]        a_min;
    logic signed [32:0] diff_sel;
    logic signed [31:0] vel_lat;
    logic signed [51:0] t_now;
    logic signed [51:0] res_now;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] out_full [3];
    logic signed [VALUE_WIDTH-1:0] out_sat [3];

    // table access
    assign wa_full = WAW'(i_slot) * WAW'(WORDS_PER_SOLID) + WAW'(i_word_select);
    assign wr_ok   = (int'(i_slot) < MAX_SOLIDS) && (int'(i_word_select) < WORDS_PER_SOLID);
    assign rd_addr = r_base + AW'(i_cmd.step[3:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && wr_ok) begin
            r_mem[wa_full[AW-1:0]] <= i_word_value;
        end
        if (i_cmd.phase == ST_FETCH) begin
            r_word[i_cmd.step[3:0]] <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.base_clr) begin
            r_base <= '0;
        end else if (i_cmd.base_adv) begin
            r_base <= r_base + AW'(WORDS_PER_SOLID);
        end
        if (i_cmd.cell_ld) begin
            r_cell[0] <= i_cell_x;
            r_cell[1] <= i_cell_y;
            r_cell[2] <= i_cell_z;
            r_vel[0]  <= i_vel_u;
            r_vel[1]  <= i_vel_v;
            r_vel[2]  <= i_vel_w;
        end
    end

    assign o_stat.sphere = (r_word[W_SHAPE] == SHAPE_SPHERE);
    assign o_stat.box    = (r_word[W_SHAPE] == SHAPE_BOX);

    // per-axis offsets from the solid center
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dd[k]  = {r_cell[k][31], r_cell[k]} - {r_word[W_CX+k][31], r_word[W_CX+k]};
            mag[k] = dd[k][32] ? 32'(-dd[k]) : dd[k][31:0];
        end
        unique case (i_cmd.step[1:0])
            2'd0:    begin mag_sel = mag[0]; half_sel = r_word[W_HX];     end
            2'd1:    begin mag_sel = mag[1]; half_sel = r_word[W_HX + 1]; end
            2'd2:    begin mag_sel = mag[2]; half_sel = r_word[W_HX + 2]; end
            default: begin mag_sel = '0;     half_sel = '0;               end
        endcase
        e_sel  = $signed({2'b00, mag_sel}) - {{2{half_sel[31]}}, half_sel};
        sum_nx = {1'b0, r_sum} + {1'b0, r_prod[63:0]};
        sq_t   = r_sq_r + r_sq_bit;
    end

    // distance, width and fraction
    always_comb begin
        if (o_stat.sphere) begin
            d_now = $signed({3'b000, r_sq_r[31:0]}) -
                    {{3{r_word[W_RADIUS][31]}}, r_word[W_RADIUS]};
        end else begin
            d_now = {r_boxd[33], r_boxd};
        end
        w_eff   = (r_word[W_WIDTH] > 32'sd0) ? r_word[W_WIDTH][30:0] : i_dwidth;
        d_mag   = r_d[34] ? 34'(-r_d) : r_d[33:0];
        num0    = {d_mag, 16'h0000};
        den_lim = {1'b0, w_eff, 18'h00000};
        qs      = r_d[34] ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        f_raw   = 21'sd32768 - {qs[19], qs};
        if (w_eff == '0) begin
            f_now = r_d[34] ? ONE_Q : 17'd0;
        end else if (f_raw < 21'sd0) begin
            f_now = 17'd0;
        end else if (f_raw > 21'sd65536) begin
            f_now = ONE_Q;
        end else begin
            f_now = f_raw[16:0];
        end
    end

    assign o_stat.f_pos = (f_now != 17'd0);

    // shared multiplier operands
    always_comb begin
        a_min = (i_blend > ONE_Q) ? ONE_Q : i_blend;
        unique case (i_cmd.step[2:0])
            3'd2:    begin diff_sel = {r_vel[0][31], r_vel[0]} - {r_word[W_VX][31], r_word[W_VX]}; end
            3'd3:    begin diff_sel = {r_vel[1][31], r_vel[1]} -
                                      {r_word[W_VX+1][31], r_word[W_VX+1]}; end
            3'd4:    begin diff_sel = {r_vel[2][31], r_vel[2]} -
                                      {r_word[W_VX+2][31], r_word[W_VX+2]}; end
            default: begin diff_sel = '0; end
        endcase
        if (i_mode) begin
            diff_sel = -diff_sel;
        end
        unique case (i_cmd.step[2:0])
            3'd3:    vel_lat = r_vel[0];
            3'd4:    vel_lat = r_vel[1];
            default: vel_lat = r_vel[2];
        endcase
        t_now   = trunc16(r_prod);
        res_now = i_mode ? ({{20{vel_lat[31]}}, vel_lat} + t_now) : -t_now;
        mul_a   = '0;
        mul_b   = '0;
        if (i_cmd.phase == ST_DIST) begin
            mul_a = $signed({2'b00, mag_sel});
            mul_b = $signed({2'b00, mag_sel});
        end else if (i_cmd.phase == ST_APPLY) begin
            if (i_cmd.step == 6'd0) begin
                mul_a = i_mode ? $signed({17'd0, a_min}) :
                                 {{2{r_word[W_PENALTY][31]}}, r_word[W_PENALTY]};
                mul_b = $signed({17'd0, r_f});
            end else begin
                mul_a = r_coef;
                mul_b = {diff_sel[32], diff_sel};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (i_cmd.phase)
            ST_DIST: begin
                if (i_cmd.step == 6'd0) begin
                    r_sum  <= '0;
                    r_boxd <= e_sel;
                end else begin
                    r_sum <= sum_nx[64] ? '1 : sum_nx[63:0];
                    if (i_cmd.step != DIST_LAST && e_sel > r_boxd) begin
                        r_boxd <= e_sel;
                    end
                end
            end
            ST_SQRT: begin
                if (i_cmd.step == 6'd0) begin
                    r_sq_n   <= r_sum;
                    r_sq_r   <= '0;
                    r_sq_bit <= 64'h4000_0000_0000_0000;
                end else begin
                    if (r_sq_n >= sq_t) begin
                        r_sq_n <= r_sq_n - sq_t;
                        r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                    end else begin
                        r_sq_r <= r_sq_r >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                end
            end
            ST_DIV: begin
                if (i_cmd.step == 6'd0) begin
                    r_d <= d_now;
                end else if (i_cmd.step == 6'd1) begin
                    // quotient beyond 2^18 clamps the fraction anyway
                    r_num  <= num0;
                    r_den  <= {2'b00, w_eff, 17'h00000};
                    r_qsat <= (num0 >= den_lim);
                    r_q    <= (num0 >= den_lim) ? 19'h40000 : 19'h00000;
                end else if (!r_qsat) begin
                    if (r_num >= r_den) begin
                        r_num <= r_num - r_den;
                        r_q   <= {r_q[17:0], 1'b1};
                    end else begin
                        r_q <= {r_q[17:0], 1'b0};
                    end
                    r_den <= r_den >> 1;
                end
            end
            ST_FRAC: begin
                r_f <= f_now;
            end
            ST_APPLY: begin
                if (i_cmd.step == 6'd1) begin
                    r_coef <= i_mode ? $signed({1'b0, r_prod[48:16]}) : t_now[33:0];
                end
                // steps 3 to 5 write the x, y and z results
                if (i_cmd.step >= 6'd3) begin
                    r_res[2'(i_cmd.step - 6'd3)] <= res_now;
                end
            end
            default: begin
            end
        endcase
    end

    // result stage with saturation
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.hit) begin
                out_full[k] = {{16{r_res[k][51]}}, r_res[k]};
            end else if (i_mode) begin
                out_full[k] = {{36{r_vel[k][31]}}, r_vel[k]};
            end else begin
                out_full[k] = '0;
            end
            if (out_full[k] > SAT_HI) begin
                out_sat[k] = SAT_HI[VALUE_WIDTH-1:0];
            end else if (out_full[k] < SAT_LO) begin
                out_sat[k] = SAT_LO[VALUE_WIDTH-1:0];
            end else begin
                out_sat[k] = out_full[k][VALUE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_out_x        <= out_sat[0];
            o_out_y        <= out_sat[1];
            o_out_z        <= out_sat[2];
            o_matched      <= i_cmd.hit;
            o_matched_slot <= i_cmd.hit ? i_cmd.hit_slot : 3'd0;
        end
    end
endmodule

@@ src/isp_checker.sv @@
module isp_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [VALUE_WIDTH-1:0] i_out_x,
    input logic [VALUE_WIDTH-1:0] i_out_y,
    input logic [VALUE_WIDTH-1:0] i_out_z,
    input logic                   i_matched,
    input logic [2:0]             i_matched_slot,
    input logic                   i_pready
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x) &&
        $stable(i_out_y) && $stable(i_out_z) && $stable(i_matched) &&
        $stable(i_matched_slot))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_matched |-> i_matched_slot == 3'd0)
        else $error("slot set without match");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("config port stalled");
endmodule

bind immersed_solid_penalty_cell_core isp_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_isp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_x        (o_out.out_x),
    .i_out_y        (o_out.out_y),
    .i_out_z        (o_out.out_z),
    .i_matched      (o_out.matched),
    .i_matched_slot (o_out.matched_slot),
    .i_pready       (pready)
);
